// File: rtl/core/big5_text_glyph_sequencer_defines.svh
// assertion macros for the glyph sequencer
`ifndef BIG5_TEXT_GLYPH_SEQUENCER_DEFINES_SVH
`define BIG5_TEXT_GLYPH_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B5G_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph sequencer assertion failed");

// next-cycle implication
`define B5G_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph sequencer assertion failed");

`else

`define B5G_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define B5G_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/b5g_pkg.sv
`default_nettype none

package b5g_pkg;

   // register indexes
   typedef enum logic [1:0] {
      CSR_ASCII_ADVANCE       = 2'd0,
      CSR_DOUBLE_BYTE_ADVANCE = 2'd1,
      CSR_UNDERSCORE_STEP     = 2'd2
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_GLYPH = 2'd0,
      STATUS_TERM  = 2'd1,
      STATUS_TRUNC = 2'd2
   } status_type;

   // glyph kinds
   localparam logic KIND_ASCII = 1'b0;
   localparam logic KIND_BIG5  = 1'b1;

   // byte constants
   localparam logic [7:0]  LEAD_LIMIT       = 8'h7f;
   localparam logic [7:0]  UNDERSCORE_BYTE  = 8'h5f;
   localparam logic [15:0] UNDERSCORE_GLYPH = 16'd32;

   // reset values of the advance registers
   localparam logic [7:0] ASCII_ADVANCE_RESET       = 8'd8;
   localparam logic [7:0] DOUBLE_BYTE_ADVANCE_RESET = 8'd16;
   localparam logic [7:0] UNDERSCORE_STEP_RESET     = 8'd8;

   typedef struct packed {
      logic [7:0] ascii_advance;
      logic [7:0] double_byte_advance;
      logic [7:0] underscore_step;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        glyph_kind;
      logic [15:0] char_code;
      logic [15:0] place_x;
      logic [15:0] place_y;
      logic        string_done;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/big5_text_glyph_sequencer.sv
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    text_byte, starts/ends_string, start_x/y
// rsp       out        rsp_valid/rsp_ready    status, glyph_kind, char_code, place_x/y, done
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one byte is taken per cycle while req_ready is high; its glyph is registered in the output register, or in the skid
// entry while the output waits; the decode and the cursor adds sit between the state registers and the
// output register; bytes outside a string and lead bytes that do not end it give no glyph
// a skid entry lets one more byte in while a glyph waits; req_ready drops when full
// reset clears the decoder (no string active) and loads the advance defaults
// csr_ready is always high
`default_nettype none

`include "big5_text_glyph_sequencer_defines.svh"

module big5_text_glyph_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_text_byte,
   input  wire logic               req_starts_string,
   input  wire logic               req_ends_string,
   input  wire logic signed [15:0] req_start_x,
   input  wire logic signed [15:0] req_start_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_glyph_kind,
   output logic [15:0]             rsp_char_code,
   output logic signed [15:0]      rsp_place_x,
   output logic signed [15:0]      rsp_place_y,
   output logic                    rsp_string_done,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_data
);
   import b5g_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type rsp_q;
   logic       res_valid;
   logic       req_accept;

   assign req_accept = req_valid & req_ready;

   // configuration registers
   b5g_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // byte decode and cursor
   b5g_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .text_byte     (req_text_byte),
      .starts_string (req_starts_string),
      .ends_string   (req_ends_string),
      .start_x       ($unsigned(req_start_x)),
      .start_y       ($unsigned(req_start_y)),
      .cfg           (cfg),
      .res_valid     (res_valid),
      .res           (res)
   );

   // result register and skid
   b5g_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_q)
   );

   assign rsp_status      = rsp_q.status;
   assign rsp_glyph_kind  = rsp_q.glyph_kind;
   assign rsp_char_code   = rsp_q.char_code;
   assign rsp_place_x     = $signed(rsp_q.place_x);
   assign rsp_place_y     = $signed(rsp_q.place_y);
   assign rsp_string_done = rsp_q.string_done;

   // a full skid means a glyph is waiting in the output register
   `B5G_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, !req_ready, rsp_valid)
   // truncated code is a double-byte kind and ends the string
   `B5G_ASSERT_IMPLIES(a_trunc_shape, clock, reset, rsp_valid && (rsp_status == STATUS_TRUNC), rsp_string_done && (rsp_glyph_kind == KIND_BIG5))
   // terminator carries code zero and ends the string
   `B5G_ASSERT_IMPLIES(a_term_shape, clock, reset, rsp_valid && (rsp_status == STATUS_TERM), rsp_string_done && (rsp_char_code == 16'h0000))
   // a glyph item taken into an empty output shows up next cycle
   `B5G_ASSERT_NEXT(a_res_lands, clock, reset, res_valid && !rsp_valid, rsp_valid)

endmodule

`default_nettype wire

// File: rtl/core/b5g_csr.sv
`default_nettype none

module b5g_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [7:0]      csr_data,
   output b5g_pkg::cfg_type     cfg
);
   import b5g_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown index ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ASCII_ADVANCE:       cfg_in.ascii_advance       = csr_data;
            CSR_DOUBLE_BYTE_ADVANCE: cfg_in.double_byte_advance = csr_data;
            CSR_UNDERSCORE_STEP:     cfg_in.underscore_step     = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ascii_advance       <= ASCII_ADVANCE_RESET;
         cfg_ff.double_byte_advance <= DOUBLE_BYTE_ADVANCE_RESET;
         cfg_ff.underscore_step     <= UNDERSCORE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/b5g_decode.sv
`default_nettype none

module b5g_decode (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      text_byte,
   input  wire logic            starts_string,
   input  wire logic            ends_string,
   input  wire logic [15:0]     start_x,
   input  wire logic [15:0]     start_y,
   input  wire b5g_pkg::cfg_type cfg,
   output logic                 res_valid,
   output b5g_pkg::result_type  res
);
   import b5g_pkg::*;

   logic        lead_pending_ff, lead_pending_in;
   logic [7:0]  lead_byte_ff, lead_byte_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] line_y_ff, line_y_in;
   logic        finished_ff, finished_in;

   logic        pend;
   logic        fin;
   logic [15:0] cur_x;
   logic [15:0] cur_y;
   logic        emit;

   // start of string overrides the held state
   always_comb begin
      pend  = starts_string ? 1'b0 : lead_pending_ff;
      fin   = starts_string ? 1'b0 : finished_ff;
      cur_x = starts_string ? start_x : cursor_x_ff;
      cur_y = starts_string ? start_y : line_y_ff;
   end

   // byte decode and cursor advance
   always_comb begin
      emit            = 1'b0;
      res.status      = STATUS_GLYPH;
      res.glyph_kind  = KIND_ASCII;
      res.char_code   = {8'h00, text_byte};
      res.place_x     = cur_x;
      res.place_y     = cur_y;
      res.string_done = ends_string;
      lead_pending_in = pend;
      lead_byte_in    = lead_byte_ff;
      cursor_x_in     = cur_x;
      line_y_in       = cur_y;
      finished_in     = fin;
      if (fin) begin
         emit = 1'b0;
      end else if (pend) begin
         // trail byte completes the double-byte code
         emit            = 1'b1;
         res.glyph_kind  = KIND_BIG5;
         res.char_code   = {lead_byte_ff, text_byte};
         lead_pending_in = 1'b0;
         cursor_x_in     = cur_x + {8'h00, cfg.double_byte_advance};
         finished_in     = ends_string;
      end else if (text_byte == 8'h00) begin
         // terminator
         emit            = 1'b1;
         res.status      = STATUS_TERM;
         res.char_code   = 16'h0000;
         res.string_done = 1'b1;
         finished_in     = 1'b1;
      end else if (text_byte > LEAD_LIMIT) begin
         if (ends_string) begin
            // lead byte with nothing after it
            emit            = 1'b1;
            res.status      = STATUS_TRUNC;
            res.glyph_kind  = KIND_BIG5;
            res.char_code   = {text_byte, 8'h00};
            res.string_done = 1'b1;
            finished_in     = 1'b1;
         end else begin
            lead_pending_in = 1'b1;
            lead_byte_in    = text_byte;
         end
      end else if (text_byte == UNDERSCORE_BYTE) begin
         emit          = 1'b1;
         res.char_code = UNDERSCORE_GLYPH;
         cursor_x_in   = cur_x + {8'h00, cfg.underscore_step};
         finished_in   = ends_string;
      end else begin
         emit        = 1'b1;
         cursor_x_in = cur_x + {8'h00, cfg.ascii_advance};
         finished_in = ends_string;
      end
      res_valid = accept & emit;
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= 8'h00;
         cursor_x_ff     <= 16'h0000;
         line_y_ff       <= 16'h0000;
         finished_ff     <= 1'b1;
      end else if (accept) begin
         lead_pending_ff <= lead_pending_in;
         lead_byte_ff    <= lead_byte_in;
         cursor_x_ff     <= cursor_x_in;
         line_y_ff       <= line_y_in;
         finished_ff     <= finished_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/b5g_out_reg.sv
`default_nettype none

module b5g_out_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            res_valid,
   input  wire b5g_pkg::result_type res,
   output logic                 in_ready,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output b5g_pkg::result_type  out_data
);
   import b5g_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // output register with one skid entry behind it
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_valid_ff && out_ready) begin
         main_valid_in = skid_valid_ff;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
